FILE: sv/icfm_pkg.sv
// Package for the input capture frequency meter.
// Holds shared widths, register and event codes, and the controller/datapath structs.
// No dependencies.
package icfm_pkg;

    localparam int COUNTER_WIDTH = 16;
    localparam int CAP_W         = 16;
    localparam int CAP_BITS      = (COUNTER_WIDTH < CAP_W) ? COUNTER_WIDTH : CAP_W;
    localparam logic [CAP_W-1:0] CAP_MASK = CAP_W'((33'd1 << CAP_BITS) - 33'd1);

    localparam int DATA_W     = 32;
    localparam int DIV_STEPS  = DATA_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam logic [1:0] REG_TICK_RATE  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_MS = 2'd1;
    localparam logic [1:0] REG_PERIOD_TOP = 2'd2;

    localparam logic [31:0] TICK_RATE_RST  = 32'd72000000;
    localparam logic [15:0] TIMEOUT_MS_RST = 16'd2000;
    localparam logic [15:0] PERIOD_TOP_RST = 16'hFFFF;

    // Event codes
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_OVF     = 2'd1;
    localparam logic [1:0] MODE_CAP     = 2'd2;
    localparam logic [1:0] MODE_OVF_CAP = 2'd3;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic mul;
        logic period;
        logic div_step;
        logic freq_store;
        logic load_out;
    } icfm_cmd_t;

    typedef struct packed {
        logic pair;
        logic period_zero;
        logic div_last;
    } icfm_sts_t;

endpackage

FILE: sv/icfm_ctrl.sv
// Controller state machine for the input capture frequency meter.
// Sequences event execution, period computation and the divider.
// Depends on icfm_pkg.
module icfm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  icfm_pkg::icfm_sts_t sts,
    output icfm_pkg::icfm_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_PERIOD = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_STORE  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.pair ? ST_MUL : ST_DONE;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_PERIOD;
            end
            ST_PERIOD:
            begin
                cmd.period = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // zero period: keep the old frequency
                if (sts.period_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (sts.div_last)
                    begin
                        state_next = ST_STORE;
                    end
                end
            end
            ST_STORE:
            begin
                cmd.freq_store = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/icfm_dp.sv
// Datapath for the input capture frequency meter.
// Holds configuration, measurement state, the period multiplier, a radix-2
// divider and the output register. Depends on icfm_pkg.
module icfm_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic [1:0]        mode,
    input  logic [15:0]       capture_value,
    output logic [31:0]       frequency,
    output logic [31:0]       period_ticks,
    output logic              measured,
    input  icfm_pkg::icfm_cmd_t cmd,
    output icfm_pkg::icfm_sts_t sts
);

    logic [31:0] tick_rate_reg;
    logic [15:0] timeout_ms_reg;
    logic [15:0] period_top_reg;

    logic [31:0] ovf_cnt_reg;
    logic        first_taken_reg;
    logic [15:0] first_capture_reg;
    logic [15:0] timeout_left_reg;
    logic [31:0] freq_reg;
    logic [31:0] period_reg;
    logic        measured_reg;

    logic [1:0]  mode_reg;
    logic [15:0] cap_reg;
    logic [31:0] prod_reg;

    logic [32:0] rem_reg;
    logic [31:0] quot_reg;
    logic [icfm_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic [31:0] freq_out_reg;
    logic [31:0] period_out_reg;
    logic        measured_out_reg;

    logic        is_tick;
    logic        has_ovf;
    logic        has_cap;
    logic [16:0] wrap_len;
    logic [48:0] prod_full;
    logic [31:0] period_next;
    logic [32:0] rem_shift;
    logic        rem_ge;
    logic [32:0] rem_next;
    logic [31:0] quot_next;

    assign is_tick = (mode_reg == icfm_pkg::MODE_TICK);
    assign has_ovf = mode_reg inside {icfm_pkg::MODE_OVF, icfm_pkg::MODE_OVF_CAP};
    assign has_cap = mode_reg inside {icfm_pkg::MODE_CAP, icfm_pkg::MODE_OVF_CAP};

    assign wrap_len    = {1'b0, period_top_reg} + 17'd1;
    assign prod_full   = ovf_cnt_reg * wrap_len;
    assign period_next = prod_reg + {16'd0, cap_reg} - {16'd0, first_capture_reg};

    // one restoring divide step
    assign rem_shift = {rem_reg[31:0], quot_reg[31]};
    assign rem_ge    = (rem_shift >= {1'b0, period_reg});
    assign rem_next  = rem_ge ? (rem_shift - {1'b0, period_reg}) : rem_shift;
    assign quot_next = {quot_reg[30:0], rem_ge};

    assign sts.pair        = has_cap && first_taken_reg;
    assign sts.period_zero = (period_reg == 32'd0);
    assign sts.div_last    = (div_cnt_reg == icfm_pkg::DIV_CNT_W'(icfm_pkg::DIV_STEPS - 1));

    assign frequency    = freq_out_reg;
    assign period_ticks = period_out_reg;
    assign measured     = measured_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg  <= icfm_pkg::TICK_RATE_RST;
            timeout_ms_reg <= icfm_pkg::TIMEOUT_MS_RST;
            period_top_reg <= icfm_pkg::PERIOD_TOP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                icfm_pkg::REG_TICK_RATE:  tick_rate_reg  <= cfg_data;
                icfm_pkg::REG_TIMEOUT_MS: timeout_ms_reg <= cfg_data[15:0];
                icfm_pkg::REG_PERIOD_TOP: period_top_reg <= cfg_data[15:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_cnt_reg       <= '0;
            first_taken_reg   <= 1'b0;
            first_capture_reg <= '0;
            timeout_left_reg  <= '0;
            freq_reg          <= '0;
            period_reg        <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                if (is_tick)
                begin
                    if (timeout_left_reg != 16'd0)
                    begin
                        timeout_left_reg <= timeout_left_reg - 16'd1;
                    end
                    else
                    begin
                        freq_reg    <= '0;
                        ovf_cnt_reg <= '0;
                    end
                end
                else
                begin
                    if (has_ovf)
                    begin
                        ovf_cnt_reg <= ovf_cnt_reg + 32'd1;
                    end
                    if (has_cap)
                    begin
                        timeout_left_reg <= timeout_ms_reg;
                        if (!first_taken_reg)
                        begin
                            // open a pair: overrides the overflow increment
                            first_capture_reg <= cap_reg;
                            ovf_cnt_reg       <= '0;
                            first_taken_reg   <= 1'b1;
                        end
                        else
                        begin
                            first_taken_reg <= 1'b0;
                        end
                    end
                end
            end
            if (cmd.period)
            begin
                period_reg <= period_next;
            end
            if (cmd.freq_store)
            begin
                freq_reg <= quot_reg;
            end
        end
    end

    // item, product, divider and output registers carry payload only
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= mode;
            cap_reg  <= capture_value & icfm_pkg::CAP_MASK;
        end
        if (cmd.exec)
        begin
            measured_reg <= sts.pair;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full[31:0];
        end
        if (cmd.period)
        begin
            rem_reg     <= '0;
            quot_reg    <= tick_rate_reg;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            quot_reg    <= quot_next;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            freq_out_reg     <= freq_reg;
            period_out_reg   <= period_reg;
            measured_out_reg <= measured_reg;
        end
    end

endmodule

FILE: sv/input_capture_frequency_meter.sv
// Top level of the input capture frequency meter (reciprocal counter).
// Joins the controller and the datapath; depends on icfm_pkg, icfm_ctrl, icfm_dp.
//
//   channel   handshake             payload
//   -------   -------------------   ---------------------------------------
//   input     in_valid / in_ready   mode, capture_value
//   output    out_valid / out_ready frequency, period_ticks, measured
//   config    cfg_we                cfg_index, cfg_data
//
// One request at a time. Ticks, overflows and a pair's first capture go straight
// from execution to the output register; a pair's second capture also runs the
// multiplier, the period step and the 32 steps of the radix-2 divider
// (tick_rate / period). A zero period skips the divider. A pending result holds
// in the output register while the next request is accepted; results are never
// dropped. Reset restores register defaults and clears all measurement state.
module input_capture_frequency_meter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] capture_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] frequency,
    output logic [31:0] period_ticks,
    output logic        measured
);

    icfm_pkg::icfm_cmd_t cmd;
    icfm_pkg::icfm_sts_t sts;

    icfm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    icfm_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .capture_value (capture_value),
        .frequency     (frequency),
        .period_ticks  (period_ticks),
        .measured      (measured),
        .cmd           (cmd),
        .sts           (sts)
    );

    // one request in flight: acceptance drops ready
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    // never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("output register overwritten");

    // divider never runs on a zero period
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !sts.period_zero)
        else $error("divide step with zero period");

    // a new result appears only as the controller returns to idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised outside idle");

endmodule

FILE: verif/testbench.sv
// Testbench for input_capture_frequency_meter: event stream in, one reading out per event.
// Runs a directed table, then random capture pairs and noise, and checks each reading
// against its own model of the meter or a pinned row value. Depends on icfm_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 240;

    typedef struct packed {
        logic [31:0] freq;
        logic [31:0] period;
        logic        measured;
    } reading_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_PINNED, ROW_CFG} row_kind_t;

    // sel is the event mode or the register index, val the capture or the write data
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  sel;
        logic [31:0] val;
        reading_t    want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = icfm_pkg::REG_TICK_RATE;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = icfm_pkg::MODE_TICK;
    logic [15:0] capture_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] frequency;
    logic [31:0] period_ticks;
    logic        measured;

    // Meter model: configuration copy and measurement state
    logic [31:0] cfg_rate = icfm_pkg::TICK_RATE_RST;
    logic [15:0] cfg_timeout = icfm_pkg::TIMEOUT_MS_RST;
    logic [15:0] cfg_top = icfm_pkg::PERIOD_TOP_RST;
    logic [31:0] ovf_count = '0;
    logic        have_first = 1'b0;
    logic [15:0] first_cap = '0;
    logic [15:0] ms_left = '0;
    logic [31:0] freq_now = '0;
    logic [31:0] period_now = '0;

    reading_t    readings_due[$];
    logic        pin_on = 1'b0;
    reading_t    pin_reading = '0;
    bit          steady = 1'b0;
    int          error_count = 0;
    int          events_sent = 0;

    input_capture_frequency_meter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .capture_value (capture_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frequency     (frequency),
        .period_ticks  (period_ticks),
        .measured      (measured)
    );

    always #4 clk = ~clk;

    task automatic meter_step(input logic [1:0] ev, input logic [15:0] cap,
                              output reading_t r);
        logic [15:0] cap_m;
        logic [63:0] span;
        logic [31:0] ticks;
        cap_m = cap & icfm_pkg::CAP_MASK;
        r.measured = 1'b0;
        if (ev == icfm_pkg::MODE_TICK)
        begin
            if (ms_left != 16'd0)
                ms_left = ms_left - 16'd1;
            else
            begin
                freq_now = '0;
                ovf_count = '0;
            end
        end
        else
        begin
            if (ev inside {icfm_pkg::MODE_OVF, icfm_pkg::MODE_OVF_CAP})
                ovf_count = ovf_count + 32'd1;
            if (ev inside {icfm_pkg::MODE_CAP, icfm_pkg::MODE_OVF_CAP})
            begin
                ms_left = cfg_timeout;
                if (!have_first)
                begin
                    first_cap = cap_m;
                    ovf_count = '0;
                    have_first = 1'b1;
                end
                else
                begin
                    // all period arithmetic wraps at 32 bits
                    span = 64'(ovf_count) * (64'(cfg_top) + 64'd1);
                    ticks = span[31:0] + 32'(cap_m) - 32'(first_cap);
                    period_now = ticks;
                    if (ticks != 32'd0)
                        freq_now = cfg_rate / ticks;
                    have_first = 1'b0;
                    r.measured = 1'b1;
                end
            end
        end
        r.freq = freq_now;
        r.period = period_now;
    endtask

    // Check finished readings first, then predict the request taken at this edge
    always @(posedge clk)
    begin
        reading_t got;
        reading_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{frequency, period_ticks, measured};
                if (readings_due.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected reading: freq %0d period %0d measured %0b",
                                 frequency, period_ticks, measured);
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (got.freq !== want.freq || got.period !== want.period
                        || got.measured !== want.measured)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: exp freq %0d period %0d measured %0b,",
                                     want.freq, want.period, want.measured,
                                     " got freq %0d period %0d measured %0b",
                                     got.freq, got.period, got.measured);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                meter_step(mode, capture_value, want);
                if (pin_on)
                    want = pin_reading;
                readings_due.push_back(want);
            end
        end
    end

    // Result side: stall about 15 percent of the time unless in a steady stretch
    always @(negedge clk)
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 15);

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("testbench: done, errors");
        $finish;
    end

    // All stimulus tasks start and end at a falling edge
    task automatic send_event(input logic [1:0] ev, input logic [15:0] cap,
                              input logic pinned, input reading_t pin);
        if (!steady && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= ev;
        capture_value <= cap;
        pin_on <= pinned;
        pin_reading <= pin;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        events_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (idx)
            icfm_pkg::REG_TICK_RATE:  cfg_rate = data;
            icfm_pkg::REG_TIMEOUT_MS: cfg_timeout = data[15:0];
            icfm_pkg::REG_PERIOD_TOP: cfg_top = data[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] pick_capture(input logic [15:0] prev);
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return prev;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_capture_mode();
        return $urandom_range(1) ? icfm_pkg::MODE_CAP : icfm_pkg::MODE_OVF_CAP;
    endfunction

    // Well-formed measurement: first capture, filler ticks and overflows, second capture
    task automatic run_pair();
        logic [15:0] c0;
        int fill;
        c0 = pick_capture(16'h0000);
        send_event(pick_capture_mode(), c0, 1'b0, '0);
        fill = $urandom_range(6);
        repeat (fill)
            send_event($urandom_range(1) ? icfm_pkg::MODE_TICK : icfm_pkg::MODE_OVF,
                       16'($urandom), 1'b0, '0);
        send_event(pick_capture_mode(), pick_capture(c0), 1'b0, '0);
    endtask

    task automatic run_noise();
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(12, 1))
                send_event(icfm_pkg::MODE_TICK, 16'($urandom), 1'b0, '0);
        else
            send_event(2'($urandom_range(3)), 16'($urandom), 1'b0, '0);
    endtask

    function automatic dir_row_t plan_row(input row_kind_t kind, input logic [1:0] sel,
                                          input logic [31:0] val, input logic [31:0] f,
                                          input logic [31:0] p, input logic m);
        dir_row_t r;
        r.kind = kind;
        r.sel = sel;
        r.val = val;
        r.want = '{f, p, m};
        return r;
    endfunction

    initial
    begin : stimulus
        dir_row_t plan[$];
        int target;
        bit paused;
        logic [31:0] rate;
        logic [15:0] tmo;
        logic [15:0] top;

        // kind, sel, val, then freq, period, measured for pinned rows
        plan.push_back(plan_row(ROW_PINNED, icfm_pkg::MODE_TICK, 32'h0, 32'd0, 32'd0, 1'b0));
        plan.push_back(plan_row(ROW_PINNED, icfm_pkg::MODE_CAP, 32'hFFFF, 32'd0, 32'd0, 1'b0));
        plan.push_back(plan_row(ROW_PINNED, icfm_pkg::MODE_OVF, 32'h0, 32'd0, 32'd0, 1'b0));
        plan.push_back(plan_row(ROW_PINNED, icfm_pkg::MODE_CAP, 32'h0,
                                32'd72000000, 32'd1, 1'b1));
        plan.push_back(plan_row(ROW_PINNED, icfm_pkg::MODE_CAP, 32'd100,
                                32'd72000000, 32'd1, 1'b0));
        plan.push_back(plan_row(ROW_PINNED, icfm_pkg::MODE_CAP, 32'd100,
                                32'd72000000, 32'd0, 1'b1));
        plan.push_back(plan_row(ROW_PINNED, icfm_pkg::MODE_OVF_CAP, 32'h0,
                                32'd72000000, 32'd0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_CAP, 32'hFFFF, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_CAP, 32'hFFFF, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_CAP, 32'h0, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_OVF_CAP, 32'h5555, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_OVF_CAP, 32'hAAAA, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_TICK, 32'h0, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_CFG, icfm_pkg::REG_TIMEOUT_MS, 32'h0, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_CAP, 32'd10, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_TICK, 32'h0, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_CAP, 32'd20, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_CFG, icfm_pkg::REG_TICK_RATE, 32'h0, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_CAP, 32'h0, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_OVF, 32'h0, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_OVF_CAP, 32'd5, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_CFG, icfm_pkg::REG_PERIOD_TOP, 32'h0, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_CFG, icfm_pkg::REG_TICK_RATE, 32'hFFFFFFFF, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_CAP, 32'd7, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_OVF, 32'h0, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_OVF, 32'h0, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_PINNED, icfm_pkg::MODE_CAP, 32'd7,
                                32'h7FFFFFFF, 32'd2, 1'b1));
        plan.push_back(plan_row(ROW_CFG, icfm_pkg::REG_TIMEOUT_MS, 32'hFFFF, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_CFG, icfm_pkg::REG_PERIOD_TOP, 32'hFFFF, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_CFG, icfm_pkg::REG_TICK_RATE, 32'd1, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_CAP, 32'h0, '0, '0, 1'b0));
        plan.push_back(plan_row(ROW_ITEM, icfm_pkg::MODE_CAP, 32'h1, '0, '0, 1'b0));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(plan[i].sel, plan[i].val);
            end
            else
                send_event(plan[i].sel, plan[i].val[15:0], plan[i].kind == ROW_PINNED,
                           plan[i].want);
        end

        paused = 1'b0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    rate = icfm_pkg::TICK_RATE_RST;
                    tmo = icfm_pkg::TIMEOUT_MS_RST;
                    top = icfm_pkg::PERIOD_TOP_RST;
                end
                1:
                begin
                    rate = 32'hFFFFFFFF;
                    tmo = 16'd0;
                    top = 16'd1;
                end
                2:
                begin
                    rate = 32'd1;
                    tmo = 16'hFFFF;
                    top = 16'hFFFF;
                end
                default:
                begin
                    rate = $urandom_range(3) == 0 ? 32'($urandom_range(1000, 1)) : $urandom;
                    tmo = 16'($urandom_range(12));
                    top = 16'($urandom_range(65535, 1));
                end
            endcase
            write_reg(icfm_pkg::REG_TICK_RATE, rate);
            write_reg(icfm_pkg::REG_TIMEOUT_MS, 32'(tmo));
            write_reg(icfm_pkg::REG_PERIOD_TOP, 32'(top));
            steady = (ph == 2);
            target = events_sent + PHASE_ITEMS;
            while (events_sent < target)
            begin
                // hold requests until every reading is back
                if (ph == 3 && !paused && events_sent >= target - PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 75)
                    run_pair();
                else
                    run_noise();
            end
        end
        steady = 1'b0;

        drain();
        repeat (40) @(negedge clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
